// File: hw/rtl/separable_gaussian_blur_rgb_assert.svh
// assertion macros shared by the checker
`ifndef SEPARABLE_GAUSSIAN_BLUR_RGB_ASSERT_SVH
`define SEPARABLE_GAUSSIAN_BLUR_RGB_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define SGB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, also checked through reset
`define SGB_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/sgb_pkg.sv
`default_nettype none
package sgb_pkg;

  localparam int MAX_SIDE       = 256;
  localparam int SIDE_BITS      = $clog2(MAX_SIDE);
  localparam int DIM_BITS       = SIDE_BITS + 1;
  localparam int MAX_TAPS       = 127;
  localparam int TAP_BITS       = $clog2(MAX_TAPS + 1);
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = 16;
  localparam int PIX_BITS       = 8;
  localparam int CHANNELS       = 3;
  localparam int PIX_WORD       = PIX_BITS * CHANNELS;
  // exact row sum: 8 x 16 bit products over up to 127 taps
  localparam int RF_BITS        = PIX_BITS + COEF_BITS + TAP_BITS;
  localparam int RF_WORD        = RF_BITS * CHANNELS;
  localparam int PROD_BITS      = RF_BITS + COEF_BITS;
  localparam int ACC_BITS       = PROD_BITS + TAP_BITS;
  localparam int ADDR_BITS      = 2 * SIDE_BITS;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 9;

  typedef enum logic [1:0] {
    CMD_COEF  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ADDR = 2'd1,
    ST_WIDE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_TAPS   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_RUN
  } top_state_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_ISSUE,
    SQ_DRAIN
  } seq_state_t;

  // one multiply-accumulate step issued by the sequencer
  typedef struct packed {
    logic                 valid;
    logic                 pass;       // 0 row pass, 1 column pass
    logic                 first;
    logic                 last;
    logic                 zero_coef;
    logic [1:0]           chan;
    logic [TAP_BITS-1:0]  tap;
    logic [SIDE_BITS-1:0] rd_row;
    logic [SIDE_BITS-1:0] rd_col;
    logic [SIDE_BITS-1:0] wr_row;
    logic [SIDE_BITS-1:0] wr_col;
  } issue_t;

  // finished pixel from the accumulator
  typedef struct packed {
    logic                 valid;
    logic                 pass;
    logic [SIDE_BITS-1:0] row;
    logic [SIDE_BITS-1:0] col;
    logic [RF_WORD-1:0]   rf_data;
    logic [PIX_WORD-1:0]  blur_data;
  } wr_t;

endpackage
`default_nettype wire

// File: hw/rtl/sgb_req_if.sv
`default_nettype none
interface sgb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] row;
  logic [7:0] col;
  logic [15:0] coef_value;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, command, row, col, coef_value, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, command, row, col, coef_value, red_in, green_in, blue_in,
                output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sgb_rsp_if.sv
`default_nettype none
interface sgb_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, status, red_out, green_out, blue_out, input ready);
  modport sink (input valid, status, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sgb_cfg_if.sv
`default_nettype none
interface sgb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sgb_seq.sv
`default_nettype none
module sgb_seq import sgb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIM_BITS-1:0] width,
  input  logic [DIM_BITS-1:0] height,
  input  logic [TAP_BITS-1:0] taps,
  output issue_t              iss,
  output logic                done
);

  localparam logic [2:0] DRAIN_LAST = 3'd4;

  seq_state_t           state, state_next;
  logic                 pass;
  logic [SIDE_BITS-1:0] outer;
  logic [SIDE_BITS-1:0] inner;
  logic [TAP_BITS-1:0]  tap;
  logic [1:0]           chan;
  logic [2:0]           drain;

  logic [TAP_BITS-1:0]  tap_last;
  logic [TAP_BITS-2:0]  pad;
  logic [DIM_BITS-1:0]  n_in;
  logic [SIDE_BITS-1:0] lim_in;
  logic [SIDE_BITS-1:0] lim_out;
  logic                 chan_wrap, tap_wrap, in_wrap, out_wrap;
  logic signed [DIM_BITS+1:0] pos;
  logic [DIM_BITS:0]    pos_abs;
  logic [DIM_BITS:0]    refl;
  logic [SIDE_BITS-1:0] mir;

  // loop limits
  always_comb begin
    tap_last  = (taps == '0) ? '0 : taps - 1'b1;
    pad       = taps[TAP_BITS-1:1];
    n_in      = pass ? height : width;
    lim_in    = SIDE_BITS'(n_in - 1'b1);
    lim_out   = pass ? SIDE_BITS'(width - 1'b1) : SIDE_BITS'(height - 1'b1);
    chan_wrap = (chan == 2'(CHANNELS - 1));
    tap_wrap  = (tap == tap_last);
    in_wrap   = (inner == lim_in);
    out_wrap  = (outer == lim_out);
  end

  // reflect-101 source position along the filtered dimension
  always_comb begin
    pos     = $signed({3'b000, inner}) + $signed({4'b0000, tap})
              - $signed({5'b00000, pad});
    pos_abs = (pos < 0) ? (DIM_BITS+1)'(-pos) : (DIM_BITS+1)'(pos);
    refl    = ({n_in, 1'b0} - 2'd2) - pos_abs;
    mir     = (pos_abs >= {1'b0, n_in}) ? refl[SIDE_BITS-1:0] : pos_abs[SIDE_BITS-1:0];
  end

  always_comb begin
    iss.valid     = (state == SQ_ISSUE);
    iss.pass      = pass;
    iss.first     = (tap == '0);
    iss.last      = tap_wrap && chan_wrap;
    iss.zero_coef = (taps == '0);
    iss.chan      = chan;
    iss.tap       = tap;
    iss.rd_row    = pass ? mir : outer;
    iss.rd_col    = pass ? outer : mir;
    iss.wr_row    = pass ? inner : outer;
    iss.wr_col    = pass ? outer : inner;
    done          = (state == SQ_DRAIN) && (drain == DRAIN_LAST) && pass;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SQ_IDLE:  if (start) state_next = SQ_ISSUE;
      SQ_ISSUE: if (chan_wrap && tap_wrap && in_wrap && out_wrap) state_next = SQ_DRAIN;
      SQ_DRAIN: begin
        if (drain == DRAIN_LAST) state_next = pass ? SQ_IDLE : SQ_ISSUE;
      end
      default:  state_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pass  <= 1'b0;
      outer <= '0;
      inner <= '0;
      tap   <= '0;
      chan  <= '0;
      drain <= '0;
    end else begin
      case (state)
        SQ_IDLE: begin
          pass  <= 1'b0;
          outer <= '0;
          inner <= '0;
          tap   <= '0;
          chan  <= '0;
          drain <= '0;
        end
        SQ_ISSUE: begin
          chan <= chan_wrap ? '0 : chan + 1'b1;
          if (chan_wrap) begin
            tap <= tap_wrap ? '0 : tap + 1'b1;
            if (tap_wrap) begin
              inner <= in_wrap ? '0 : inner + 1'b1;
              if (in_wrap) outer <= out_wrap ? '0 : outer + 1'b1;
            end
          end
          drain <= '0;
        end
        SQ_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == DRAIN_LAST) pass <= 1'b1;
        end
        default: drain <= '0;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sgb_mac.sv
`default_nettype none
module sgb_mac import sgb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  issue_t               iss,
  input  logic [PIX_WORD-1:0]  src_word,
  input  logic [RF_WORD-1:0]   rf_word,
  input  logic [COEF_BITS-1:0] coef_word,
  output wr_t                  wr
);

  function automatic logic [PIX_BITS-1:0] sat(input logic [ACC_BITS-1:0] a);
    logic [ACC_BITS-2*COEF_FRAC_BITS-1:0] v;
    v = a[ACC_BITS-1:2*COEF_FRAC_BITS];
    sat = (v > {{(ACC_BITS-2*COEF_FRAC_BITS-PIX_BITS){1'b0}}, {PIX_BITS{1'b1}}})
          ? {PIX_BITS{1'b1}} : v[PIX_BITS-1:0];
  endfunction

  issue_t                 s1;
  logic                   s1_valid;
  logic [RF_BITS-1:0]     operand;
  logic [COEF_BITS-1:0]   coef_eff;
  logic                   s2_valid, s2_first, s2_last, s2_pass;
  logic [1:0]             s2_chan;
  logic [SIDE_BITS-1:0]   s2_row, s2_col;
  logic [PROD_BITS-1:0]   prod;
  logic [ACC_BITS-1:0]    acc [CHANNELS];
  logic                   s3_valid, s3_pass;
  logic [SIDE_BITS-1:0]   s3_row, s3_col;

  // operand select for the channel of this step
  always_comb begin
    case (s1.chan)
      2'd0:    operand = s1.pass ? rf_word[RF_BITS-1:0]
                                 : RF_BITS'(src_word[PIX_BITS-1:0]);
      2'd1:    operand = s1.pass ? rf_word[2*RF_BITS-1:RF_BITS]
                                 : RF_BITS'(src_word[2*PIX_BITS-1:PIX_BITS]);
      default: operand = s1.pass ? rf_word[3*RF_BITS-1:2*RF_BITS]
                                 : RF_BITS'(src_word[3*PIX_BITS-1:2*PIX_BITS]);
    endcase
    coef_eff = s1.zero_coef ? '0 : coef_word;
  end

  // control follows the memory read latency
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= iss.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2_last;
    end
  end

  // multiply stage, accumulate stage, write stage
  always_ff @(posedge clk) begin
    s1       <= iss;
    prod     <= operand * coef_eff;
    s2_first <= s1.first;
    s2_last  <= s1.last;
    s2_pass  <= s1.pass;
    s2_chan  <= s1.chan;
    s2_row   <= s1.wr_row;
    s2_col   <= s1.wr_col;
    if (s2_valid) begin
      acc[s2_chan] <= (s2_first ? '0 : acc[s2_chan]) + ACC_BITS'(prod);
    end
    s3_pass <= s2_pass;
    s3_row  <= s2_row;
    s3_col  <= s2_col;
  end

  always_comb begin
    wr.valid     = s3_valid;
    wr.pass      = s3_pass;
    wr.row       = s3_row;
    wr.col       = s3_col;
    wr.rf_data   = {acc[2][RF_BITS-1:0], acc[1][RF_BITS-1:0], acc[0][RF_BITS-1:0]};
    wr.blur_data = {sat(acc[2]), sat(acc[1]), sat(acc[0])};
  end

endmodule
`default_nettype wire

// File: hw/rtl/separable_gaussian_blur_rgb.sv
// coefficient load and pixel write: result registered in the cycle after the transaction
// pixel read: result passes through the registered image memory read and then the result register
// run: the single shared multiply-accumulate unit does one tap of one channel per cycle,
//   row pass then column pass
// reset: synchronous; clears control and then zeroes every address of the blurred image,
//   with no request taken meanwhile (configuration writes still taken)
`default_nettype none
module separable_gaussian_blur_rgb import sgb_pkg::*; (
  input logic       clk,
  input logic       rst,
  sgb_req_if.sink   req,
  sgb_rsp_if.source rsp,
  sgb_cfg_if.sink   cfg
);

  top_state_t state, state_next;

  logic [DIM_BITS-1:0]  cfg_width, cfg_height;
  logic [TAP_BITS-1:0]  cfg_taps;
  logic [DIM_BITS-1:0]  eff_w, eff_h;
  logic [ADDR_BITS-1:0] clr_cnt;

  logic                 accept, addr_bad, too_wide, start;
  logic                 load;
  status_t              load_status;
  logic [PIX_WORD-1:0]  load_pix;

  logic                 out_valid;
  status_t              out_status;
  logic [PIX_WORD-1:0]  out_pix;

  logic [COEF_BITS-1:0] coef_mem [MAX_TAPS];
  logic [PIX_WORD-1:0]  src_mem  [MAX_SIDE*MAX_SIDE];
  logic [RF_WORD-1:0]   rf_mem   [MAX_SIDE*MAX_SIDE];
  logic [PIX_WORD-1:0]  blur_mem [MAX_SIDE*MAX_SIDE];

  logic [COEF_BITS-1:0] coef_rd;
  logic [PIX_WORD-1:0]  src_rd;
  logic [RF_WORD-1:0]   rf_rd;
  logic [PIX_WORD-1:0]  blur_rd;

  issue_t iss;
  wr_t    wr;
  logic   done;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= DIM_BITS'(MAX_SIDE);
      cfg_height <= DIM_BITS'(MAX_SIDE);
      cfg_taps   <= TAP_BITS'(11);
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_WIDTH:  cfg_width  <= cfg.data;
        CFG_HEIGHT: cfg_height <= cfg.data;
        CFG_TAPS:   cfg_taps   <= cfg.data[TAP_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // effective sizes and checks
  always_comb begin
    eff_w    = (cfg_width  > DIM_BITS'(MAX_SIDE)) ? DIM_BITS'(MAX_SIDE) : cfg_width;
    eff_h    = (cfg_height > DIM_BITS'(MAX_SIDE)) ? DIM_BITS'(MAX_SIDE) : cfg_height;
    too_wide = (DIM_BITS'(cfg_taps[TAP_BITS-1:1]) >= eff_w)
            || (DIM_BITS'(cfg_taps[TAP_BITS-1:1]) >= eff_h);
    addr_bad = ({1'b0, req.row} >= eff_h) || ({1'b0, req.col} >= eff_w);
    accept   = req.valid && req.ready;
  end

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);

  // command decode and next state
  always_comb begin
    state_next  = state;
    load        = 1'b0;
    load_status = ST_OK;
    load_pix    = '0;
    start       = 1'b0;
    case (state)
      S_CLEAR: if (clr_cnt == {ADDR_BITS{1'b1}}) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(req.command))
            CMD_COEF: begin
              load        = 1'b1;
              load_status = ({1'b0, req.row} >= 9'(MAX_TAPS)) ? ST_ADDR : ST_OK;
            end
            CMD_PIXEL: begin
              load        = 1'b1;
              load_status = addr_bad ? ST_ADDR : ST_OK;
            end
            CMD_RUN: begin
              if (too_wide) begin
                load        = 1'b1;
                load_status = ST_WIDE;
              end else begin
                start      = 1'b1;
                state_next = S_RUN;
              end
            end
            CMD_READ: begin
              if (addr_bad) begin
                load        = 1'b1;
                load_status = ST_ADDR;
              end else begin
                state_next = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        load       = 1'b1;
        load_pix   = blur_rd;
        state_next = S_IDLE;
      end
      S_RUN: begin
        if (done) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= load_status;
      out_pix    <= load_pix;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.red_out   = out_pix[PIX_BITS-1:0];
  assign rsp.green_out = out_pix[2*PIX_BITS-1:PIX_BITS];
  assign rsp.blue_out  = out_pix[3*PIX_BITS-1:2*PIX_BITS];

  // coefficient and source memories
  always_ff @(posedge clk) begin
    if (accept && (cmd_t'(req.command) == CMD_COEF) && ({1'b0, req.row} < 9'(MAX_TAPS))) begin
      coef_mem[req.row[TAP_BITS-1:0]] <= req.coef_value;
    end
    coef_rd <= coef_mem[iss.tap];
  end

  always_ff @(posedge clk) begin
    if (accept && (cmd_t'(req.command) == CMD_PIXEL) && !addr_bad) begin
      src_mem[{req.row, req.col}] <= {req.blue_in, req.green_in, req.red_in};
    end
    src_rd <= src_mem[{iss.rd_row, iss.rd_col}];
  end

  // row pass results
  always_ff @(posedge clk) begin
    if (wr.valid && !wr.pass) rf_mem[{wr.row, wr.col}] <= wr.rf_data;
    rf_rd <= rf_mem[{iss.rd_row, iss.rd_col}];
  end

  // blurred image, zeroed after reset
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      blur_mem[clr_cnt] <= '0;
    end else if (wr.valid && wr.pass) begin
      blur_mem[{wr.row, wr.col}] <= wr.blur_data;
    end
    blur_rd <= blur_mem[{req.row, req.col}];
  end

  sgb_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .width  (eff_w),
    .height (eff_h),
    .taps   (cfg_taps),
    .iss    (iss),
    .done   (done)
  );

  sgb_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .iss       (iss),
    .src_word  (src_rd),
    .rf_word   (rf_rd),
    .coef_word (coef_rd),
    .wr        (wr)
  );

endmodule
`default_nettype wire

// File: hw/rtl/sgb_checker.sv
`default_nettype none
`include "separable_gaussian_blur_rgb_assert.svh"
module sgb_checker import sgb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_status,
  input logic [7:0] rsp_red,
  input logic [7:0] rsp_green,
  input logic [7:0] rsp_blue
);

  logic pix_zero;

  assign pix_zero = (rsp_red == 8'd0) && (rsp_green == 8'd0) && (rsp_blue == 8'd0);

  // a pending result stays offered
  `SGB_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

  // error results carry no pixel
  `SGB_ASSERT_IMP(a_err_zero, rsp_valid && (rsp_status != ST_OK), pix_zero)

  // only defined status codes
  `SGB_ASSERT_IMP(a_status_code, rsp_valid, rsp_status != 2'd3)

  // image clear keeps requests out after reset
  `SGB_ASSERT_NXT_ALWAYS(a_reset_busy, rst, !req_ready && !rsp_valid)

endmodule

bind separable_gaussian_blur_rgb sgb_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_red    (rsp.red_out),
  .rsp_green  (rsp.green_out),
  .rsp_blue   (rsp.blue_out)
);
`default_nettype wire
